// ----- hw/rtl/rtcm_pkg.sv -----
// shared types, constants and crc function for the rtcm3 frame receiver
`timescale 1ns / 1ps

package rtcm_pkg;

    localparam logic [7:0]  PREAMBLE       = 8'hD3;
    localparam logic [24:0] CRC_POLY       = 25'h1864CFB;
    localparam logic [10:0] MAX_FRAME_LEN  = 11'd1029;
    localparam logic [15:0] TIMEOUT_RESET  = 16'hFFFF & 16'd250;
    localparam logic [15:0] IDLE_MAX       = 16'hFFFF;
    localparam logic [9:0]  MIN_PAYLOAD    = 10'd2;
    localparam logic [10:0] FRAME_OVERHEAD = 11'd6;
    localparam logic [11:0] CRC_BYTES      = 12'd3;
    localparam logic [10:0] POS_LEN_HIGH   = 11'd1;
    localparam logic [10:0] POS_LEN_DONE   = 11'd3;
    localparam logic [10:0] POS_TYPE_HIGH  = 11'd3;
    localparam logic [10:0] POS_TYPE_LOW   = 11'd4;

    typedef enum logic
    {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } rtcm_req_kind_t;

    typedef struct packed
    {
        logic       req_type;
        logic [7:0] data_byte;
    } rtcm_item_t;

    typedef struct packed
    {
        logic        consumed;
        logic [7:0]  byte_out;
        logic        frame_end;
        logic        frame_good;
        logic        frame_bad;
        logic [11:0] last_msg;
        logic [10:0] frame_size;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } rtcm_result_t;

    // one byte of crc-24q, msb first
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [24:0] c;
        c = {1'b0, crc ^ {b, 16'h0000}};
        for (int k = 0; k < 8; k++)
        begin
            c = {c[23:0], 1'b0};
            if (c[24])
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c[23:0];
    endfunction

endpackage

// ----- hw/rtl/rtcm_req_if.sv -----
// input channel: received bytes and millisecond ticks
`timescale 1ns / 1ps

interface rtcm_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

// ----- hw/rtl/rtcm_rsp_if.sv -----
// result channel: byte routing, frame status and counters
`timescale 1ns / 1ps

interface rtcm_rsp_if;
    logic        valid;
    logic        ready;
    logic        consumed;
    logic [7:0]  byte_out;
    logic        frame_end;
    logic        frame_good;
    logic        frame_bad;
    logic [11:0] last_msg;
    logic [10:0] frame_size;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;

    modport source (
        output valid, output consumed, output byte_out, output frame_end,
        output frame_good, output frame_bad, output last_msg,
        output frame_size, output good_frames, output bad_frames,
        input ready
    );
    modport sink (
        input valid, input consumed, input byte_out, input frame_end,
        input frame_good, input frame_bad, input last_msg,
        input frame_size, input good_frames, input bad_frames,
        output ready
    );
endinterface

// ----- hw/rtl/rtcm_in_stage.sv -----
// input register for the request channel
`timescale 1ns / 1ps

module rtcm_in_stage
    import rtcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rtcm_req_if.sink   req,
    input  logic       advance,
    output logic       item_valid,
    output rtcm_item_t item
);

    logic       valid_reg;
    rtcm_item_t item_reg;
    logic       take;

    assign req.ready  = !valid_reg || advance;
    assign take       = req.valid && req.ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.req_type  <= req.req_type;
            item_reg.data_byte <= req.data_byte;
        end
    end

endmodule

// ----- hw/rtl/rtcm_frame_core.sv -----
// frame state, crc-24q accumulator, timeout and counters
`timescale 1ns / 1ps

module rtcm_frame_core
    import rtcm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         step,
    input  rtcm_item_t   item,
    output rtcm_result_t result
);

    logic [15:0] timeout_reg;
    logic [10:0] held_reg, held_next;
    logic [10:0] exp_reg, exp_next;
    logic [1:0]  len_hi_reg, len_hi_next;
    logic [7:0]  type_hi_reg, type_hi_next;
    logic [11:0] ftype_reg, ftype_next;
    logic [23:0] crc_reg, crc_next;
    logic [23:0] rcv_reg, rcv_next;
    logic [15:0] idle_reg, idle_next;
    logic [11:0] last_type_reg, last_type_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] bad_reg, bad_next;

    logic        consumed;
    logic        frame_end;
    logic        frame_good;
    logic        bad_evt;
    logic [10:0] len;
    logic [10:0] pos;
    logic [10:0] pos_next;
    logic [9:0]  payload;
    logic [10:0] total;
    logic [7:0]  b;

    always_comb
    begin
        held_next      = held_reg;
        exp_next       = exp_reg;
        len_hi_next    = len_hi_reg;
        type_hi_next   = type_hi_reg;
        ftype_next     = ftype_reg;
        crc_next       = crc_reg;
        rcv_next       = rcv_reg;
        idle_next      = idle_reg;
        last_type_next = last_type_reg;
        good_next      = good_reg;
        consumed       = 1'b0;
        frame_end      = 1'b0;
        frame_good     = 1'b0;
        bad_evt        = 1'b0;
        len            = '0;
        b              = item.data_byte;
        pos            = held_reg;
        pos_next       = held_reg + 11'd1;
        payload        = {len_hi_reg, item.data_byte};
        total          = {1'b0, payload} + FRAME_OVERHEAD;

        if (item.req_type == REQ_TICK)
        begin
            if (idle_reg < IDLE_MAX)
            begin
                idle_next = idle_reg + 16'd1;
            end
            b = 8'h00;
        end
        else if (held_reg == '0 || idle_reg > timeout_reg)
        begin
            // idle hunt, or a stale partial frame dropped before this byte
            if (held_reg != '0)
            begin
                held_next = '0;
                exp_next  = '0;
                bad_evt   = 1'b1;
            end
            if (item.data_byte == PREAMBLE)
            begin
                consumed  = 1'b1;
                held_next = 11'd1;
                exp_next  = '0;
                crc_next  = crc24q_byte(24'h000000, item.data_byte);
                rcv_next  = '0;
                idle_next = '0;
            end
        end
        else
        begin
            consumed  = 1'b1;
            idle_next = '0;
            if (held_reg >= MAX_FRAME_LEN)
            begin
                held_next = '0;
                exp_next  = '0;
                bad_evt   = 1'b1;
            end
            else
            begin
                if (pos < POS_LEN_DONE || ({1'b0, pos} + CRC_BYTES) < {1'b0, exp_reg})
                begin
                    crc_next = crc24q_byte(crc_reg, item.data_byte);
                end
                else
                begin
                    rcv_next = {rcv_reg[15:0], item.data_byte};
                end
                if (pos == POS_LEN_HIGH)
                begin
                    len_hi_next = item.data_byte[1:0];
                end
                if (pos == POS_TYPE_HIGH)
                begin
                    type_hi_next = item.data_byte;
                end
                if (pos == POS_TYPE_LOW)
                begin
                    ftype_next = {type_hi_reg, item.data_byte[7:4]};
                end
                held_next = pos_next;

                if (pos_next == POS_LEN_DONE)
                begin
                    exp_next = total;
                    if (payload < MIN_PAYLOAD || total > MAX_FRAME_LEN)
                    begin
                        held_next = '0;
                        exp_next  = '0;
                        bad_evt   = 1'b1;
                    end
                end
                else if (exp_reg != '0 && pos_next == exp_reg)
                begin
                    frame_end = 1'b1;
                    len       = pos_next;
                    if (rcv_next == crc_next)
                    begin
                        frame_good     = 1'b1;
                        good_next      = good_reg + 32'd1;
                        last_type_next = ftype_next;
                    end
                    else
                    begin
                        bad_evt = 1'b1;
                    end
                    held_next = '0;
                    exp_next  = '0;
                end
            end
        end

        bad_next = bad_reg + {31'd0, bad_evt};

        result.consumed    = consumed;
        result.byte_out    = b;
        result.frame_end   = frame_end;
        result.frame_good  = frame_good;
        result.frame_bad   = bad_evt;
        result.last_msg    = last_type_next;
        result.frame_size  = len;
        result.good_frames = good_next;
        result.bad_frames  = bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            exp_reg       <= '0;
            len_hi_reg    <= '0;
            type_hi_reg   <= '0;
            ftype_reg     <= '0;
            crc_reg       <= '0;
            rcv_reg       <= '0;
            idle_reg      <= '0;
            last_type_reg <= '0;
            good_reg      <= '0;
            bad_reg       <= '0;
        end
        else if (step)
        begin
            held_reg      <= held_next;
            exp_reg       <= exp_next;
            len_hi_reg    <= len_hi_next;
            type_hi_reg   <= type_hi_next;
            ftype_reg     <= ftype_next;
            crc_reg       <= crc_next;
            rcv_reg       <= rcv_next;
            idle_reg      <= idle_next;
            last_type_reg <= last_type_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
        end
    end

endmodule

// ----- hw/rtl/rtcm3_frame_receiver_core.sv -----
// top level of the rtcm3 frame receiver with crc-24q check
`timescale 1ns / 1ps

// Takes one item per clock unless rsp backpressure stalls it: a UART byte or
// a millisecond tick. Each transfer is registered in the input register, run
// through the frame logic and the one-byte CRC-24Q update combinationally,
// and lands in a result register that drives rsp; one result per cycle can
// be sustained while rsp is ready. The result register lets a new input
// transfer in while an earlier result waits; backpressure on rsp stalls req
// only once both registers are full. The idle timeout resets to 250 ticks;
// 65535 disables the timeout.

module rtcm3_frame_receiver_core
    import rtcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    rtcm_req_if.sink    req,
    rtcm_rsp_if.source  rsp
);

    logic         item_valid;
    rtcm_item_t   item;
    logic         step;
    rtcm_result_t result;
    logic         out_valid_reg;
    rtcm_result_t out_reg;

    assign step = item_valid && (!out_valid_reg || rsp.ready);

    rtcm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (step),
        .item_valid (item_valid),
        .item       (item)
    );

    rtcm_frame_core u_frame_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .item        (item),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.consumed    = out_reg.consumed;
    assign rsp.byte_out    = out_reg.byte_out;
    assign rsp.frame_end   = out_reg.frame_end;
    assign rsp.frame_good  = out_reg.frame_good;
    assign rsp.frame_bad   = out_reg.frame_bad;
    assign rsp.last_msg    = out_reg.last_msg;
    assign rsp.frame_size  = out_reg.frame_size;
    assign rsp.good_frames = out_reg.good_frames;
    assign rsp.bad_frames  = out_reg.bad_frames;

    // a held input item with a blocked result register must stall the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !step) |-> !req.ready)
        else $error("input accepted while input register is stuck");

    // ticks never route a byte into a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.req_type == REQ_TICK) |=> (!out_reg.consumed && !out_reg.frame_end))
        else $error("tick produced frame activity");

    // a checked frame is either good or bad, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> !(out_reg.frame_good && out_reg.frame_bad))
        else $error("frame reported good and bad together");

    // bad count moves only with the bad flag of the same result
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && $past(step) && !result.frame_bad) |->
            (result.bad_frames == out_reg.bad_frames))
        else $error("bad frame counter moved without bad flag");

endmodule

// ----- bench/tb_top.sv -----
// testbench for rtcm3_frame_receiver_core: framed byte traffic, ticks and timeout settings
`timescale 1ns / 1ps

import rtcm_pkg::*;

class rtcm_frame_tracker;
    logic [15:0]  timeout_limit;
    logic [10:0]  held;
    logic [10:0]  total_len;
    logic [1:0]   len_hi;
    logic [7:0]   type_hi;
    logic [11:0]  cur_type;
    logic [23:0]  crc_run;
    logic [23:0]  crc_tail;
    logic [15:0]  idle_cnt;
    logic [11:0]  good_type;
    logic [31:0]  good_cnt;
    logic [31:0]  bad_cnt;
    rtcm_result_t due_reports[$];
    int unsigned  mismatches;
    int unsigned  checked;

    function new();
        timeout_limit = TIMEOUT_RESET;
        held = '0;
        total_len = '0;
        len_hi = '0;
        type_hi = '0;
        cur_type = '0;
        crc_run = '0;
        crc_tail = '0;
        idle_cnt = '0;
        good_type = '0;
        good_cnt = '0;
        bad_cnt = '0;
        mismatches = 0;
        checked = 0;
    endfunction

    // crc-24q, one input bit at a time
    static function logic [23:0] crc_step(input logic [23:0] acc, input logic [7:0] b);
        logic [23:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[23] ^ b[i];
            r = {r[22:0], 1'b0};
            if (fb)
            begin
                r = r ^ CRC_POLY[23:0];
            end
        end
        return r;
    endfunction

    function void drop_frame();
        held = '0;
        total_len = '0;
        bad_cnt = bad_cnt + 32'd1;
    endfunction

    function int pending();
        return due_reports.size();
    endfunction

    function void note_item(input rtcm_req_kind_t kind, input logic [7:0] b);
        rtcm_result_t r;
        logic [31:0]  bad_prev;
        logic [10:0]  pos;
        logic [9:0]   payload;
        r = '0;
        bad_prev = bad_cnt;
        if (kind == REQ_TICK)
        begin
            if (idle_cnt != IDLE_MAX)
            begin
                idle_cnt = idle_cnt + 16'd1;
            end
        end
        else
        begin
            r.byte_out = b;
            if (held != 0 && idle_cnt > timeout_limit)
            begin
                drop_frame();
            end
            if (held == 0)
            begin
                if (b == PREAMBLE)
                begin
                    r.consumed = 1'b1;
                    held = 11'd1;
                    total_len = '0;
                    crc_run = crc_step(24'd0, b);
                    crc_tail = '0;
                    idle_cnt = '0;
                end
            end
            else
            begin
                r.consumed = 1'b1;
                idle_cnt = '0;
                if (held >= MAX_FRAME_LEN)
                begin
                    drop_frame();
                end
                else
                begin
                    pos = held;
                    if (pos < POS_LEN_DONE || pos + 11'd3 < total_len)
                    begin
                        crc_run = crc_step(crc_run, b);
                    end
                    else
                    begin
                        crc_tail = {crc_tail[15:0], b};
                    end
                    if (pos == POS_LEN_HIGH)
                    begin
                        len_hi = b[1:0];
                    end
                    if (pos == POS_TYPE_HIGH)
                    begin
                        type_hi = b;
                    end
                    if (pos == POS_TYPE_LOW)
                    begin
                        cur_type = {type_hi, b[7:4]};
                    end
                    held = pos + 11'd1;
                    if (held == POS_LEN_DONE)
                    begin
                        payload = {len_hi, b};
                        total_len = {1'b0, payload} + FRAME_OVERHEAD;
                        if (payload < MIN_PAYLOAD || total_len > MAX_FRAME_LEN)
                        begin
                            drop_frame();
                        end
                    end
                    else if (total_len != 0 && held == total_len)
                    begin
                        r.frame_end = 1'b1;
                        r.frame_size = held;
                        if (crc_tail == crc_run)
                        begin
                            r.frame_good = 1'b1;
                            good_cnt = good_cnt + 32'd1;
                            good_type = cur_type;
                        end
                        else
                        begin
                            bad_cnt = bad_cnt + 32'd1;
                        end
                        held = '0;
                        total_len = '0;
                    end
                end
            end
        end
        r.frame_bad = (bad_cnt != bad_prev);
        r.last_msg = good_type;
        r.good_frames = good_cnt;
        r.bad_frames = bad_cnt;
        due_reports.push_back(r);
    endfunction

    task report(input string what);
        mismatches++;
        if (mismatches <= 50)
        begin
            $display("mismatch at result %0d: %s", checked, what);
        end
    endtask

    task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
        begin
            report($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task check_report(input rtcm_result_t got);
        rtcm_result_t want;
        if (due_reports.size() == 0)
        begin
            report("result with nothing outstanding");
        end
        else
        begin
            want = due_reports.pop_front();
            compare_field("consumed", got.consumed, want.consumed);
            compare_field("byte_out", got.byte_out, want.byte_out);
            compare_field("frame_end", got.frame_end, want.frame_end);
            compare_field("frame_good", got.frame_good, want.frame_good);
            compare_field("frame_bad", got.frame_bad, want.frame_bad);
            compare_field("last_msg", got.last_msg, want.last_msg);
            compare_field("frame_size", got.frame_size, want.frame_size);
            compare_field("good_frames", got.good_frames, want.good_frames);
            compare_field("bad_frames", got.bad_frames, want.bad_frames);
        end
        checked++;
    endtask
endclass

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned NO_PAUSE    = 32'hFFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    bit          steady_flow;
    int unsigned items_sent;
    int unsigned cycle_count;

    rtcm_frame_tracker board;

    rtcm_req_if req_ch ();
    rtcm_rsp_if rsp_ch ();

    rtcm3_frame_receiver_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[rtcm3_frame_receiver_core] ERROR");
            $finish;
        end
    end

    task automatic send_item(input rtcm_req_kind_t kind, input logic [7:0] b);
        while (!steady_flow && $urandom_range(99) < 20)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_item(kind, b);
        items_sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.timeout_limit = value;
    endtask

    // preamble, length, payload led by the message type, crc; optional bit flip after the header; optional tick pause
    task automatic send_frame(input logic [9:0] payload_len, input logic [11:0] msg_type,
                              input bit corrupt, input int unsigned pause_at,
                              input int unsigned pause_ticks);
        logic [7:0]  frame_bytes[$];
        logic [23:0] crc;
        int unsigned flip_at;
        int unsigned i;
        frame_bytes.push_back(PREAMBLE);
        frame_bytes.push_back({($urandom_range(99) < 30) ? 6'($urandom) : 6'd0,
                               payload_len[9:8]});
        frame_bytes.push_back(payload_len[7:0]);
        for (i = 0; i < payload_len; i++)
        begin
            if (i == 0)
                frame_bytes.push_back(msg_type[11:4]);
            else if (i == 1)
                frame_bytes.push_back({msg_type[3:0], 4'($urandom)});
            else
                frame_bytes.push_back(8'($urandom));
        end
        crc = '0;
        for (i = 0; i < frame_bytes.size(); i++)
        begin
            crc = board.crc_step(crc, frame_bytes[i]);
        end
        frame_bytes.push_back(crc[23:16]);
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
        if (corrupt)
        begin
            flip_at = $urandom_range(3, frame_bytes.size() - 1);
            frame_bytes[flip_at] = frame_bytes[flip_at] ^ (8'd1 << $urandom_range(7));
        end
        for (i = 0; i < frame_bytes.size(); i++)
        begin
            if (i == pause_at)
            begin
                repeat (pause_ticks) send_item(REQ_TICK, 8'($urandom));
            end
            send_item(REQ_BYTE, frame_bytes[i]);
        end
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        int unsigned limit;
        logic [9:0]  len;
        start = items_sent;
        while (items_sent - start < count)
        begin
            pick = $urandom_range(99);
            len = ($urandom_range(99) < 90) ? 10'($urandom_range(2, 24))
                                            : 10'($urandom_range(25, 80));
            limit = board.timeout_limit;
            if (pick < 45)
                send_frame(len, 12'($urandom), 1'b0, NO_PAUSE, 0);
            else if (pick < 57)
                send_frame(len, 12'($urandom), 1'b0, $urandom_range(1, len + 5),
                           $urandom_range(1, 3));
            else if (pick < 67)
                send_frame(len, 12'($urandom), 1'b1, NO_PAUSE, 0);
            else if (pick < 74)
                send_frame(10'($urandom_range(1)), 12'($urandom), 1'b0, NO_PAUSE, 0);
            else if (pick < 82)
                send_frame(len, 12'($urandom), 1'b0, $urandom_range(1, len + 5),
                           (limit < 40) ? limit + 1 + $urandom_range(2)
                                        : $urandom_range(1, 40));
            else if (pick < 92)
                repeat ($urandom_range(1, 6)) send_item(REQ_BYTE, 8'($urandom));
            else
                repeat ($urandom_range(1, 6)) send_item(REQ_TICK, 8'($urandom));
        end
    endtask

    // result side, with one long hold-off
    initial
    begin
        int unsigned  hold_left;
        int unsigned  seen;
        bit           held_once;
        rtcm_result_t got;
        hold_left = 0;
        seen = 0;
        held_once = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.consumed, rsp_ch.byte_out, rsp_ch.frame_end,
                        rsp_ch.frame_good, rsp_ch.frame_bad, rsp_ch.last_msg,
                        rsp_ch.frame_size, rsp_ch.good_frames, rsp_ch.bad_frames};
                board.check_report(got);
                seen++;
                if (seen == 120 && !held_once)
                begin
                    hold_left = 300;
                    held_once = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 20);
            end
        end
    end

    initial
    begin
        board = new();
        items_sent = 0;
        steady_flow = 1'b0;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_BYTE;
        req_ch.data_byte <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ticks, noise extremes, good and bad frames, short length
        send_item(REQ_TICK, 8'hFF);
        send_item(REQ_BYTE, 8'h00);
        send_item(REQ_BYTE, 8'hFF);
        send_frame(10'd2, 12'hFFF, 1'b0, NO_PAUSE, 0);
        send_frame(10'd2, 12'h000, 1'b1, NO_PAUSE, 0);
        send_frame(10'd1, 12'hABC, 1'b0, NO_PAUSE, 0);

        write_timeout(16'd0);
        random_traffic(60);

        // timeout disabled: longest frame, high length bits
        write_timeout(16'hFFFF);
        steady_flow = 1'b1;
        send_frame(10'd1023, 12'($urandom), 1'b0, NO_PAUSE, 0);
        steady_flow = 1'b0;
        random_traffic(50);
        wait_drained();
        random_traffic(50);

        write_timeout(16'($urandom_range(1, 8)));
        random_traffic(80);

        write_timeout(16'($urandom));
        random_traffic(60);

        wait_drained();
        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
        begin
            $display("[rtcm3_frame_receiver_core] OK");
        end
        else
        begin
            $display("[rtcm3_frame_receiver_core] ERROR");
        end
        $finish;
    end

endmodule
